/* design/dbf_pkg.sv */
// Shared types, codes and constants of the directional border fill block.
package dbf_pkg;

  localparam int unsigned DBF_MAX_WIDTH  = 256;
  localparam int unsigned DBF_MAX_HEIGHT = 256;

  localparam int unsigned IDX_W  = 16;
  localparam int unsigned PIX_W  = 24;
  localparam int unsigned CFG_W  = 9;
  localparam int unsigned LIM_W  = 4;
  localparam int unsigned CHG_W  = 19;

  localparam logic [PIX_W-1:0] PIX_RED   = 24'hFF0000;
  localparam logic [PIX_W-1:0] PIX_WHITE = 24'hFFFFFF;
  localparam logic [PIX_W-1:0] PIX_BLACK = 24'h000000;
  localparam logic [CHG_W-1:0] CHANGE_MAX = 19'h7FFFF;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 9'd256;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 9'd256;
  localparam logic [LIM_W-1:0] LIMIT_RST  = 4'd10;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_RUN   = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NOP   = 2'd3
  } dbf_func_e;

  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_ROUND_LIMIT  = 2'd2,
    CFG_UNUSED       = 2'd3
  } dbf_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_PREV,
    ST_AT,
    ST_UPD,
    ST_CLR_RD,
    ST_CLR_WR
  } dbf_state_e;

  typedef enum logic [1:0] {
    SWP_LR,
    SWP_RL,
    SWP_TD,
    SWP_BU
  } dbf_sweep_e;

  // Host request into the engine (valid only on an accepted command).
  typedef struct packed {
    logic             wr;
    logic             run;
    logic [IDX_W-1:0] index;
    logic [PIX_W-1:0] pix;
  } dbf_host_req_t;

  // Run status back to the command side.
  typedef struct packed {
    logic             done;
    logic [LIM_W-1:0] rounds;
    logic             hit;
    logic [CHG_W-1:0] changes;
  } dbf_run_stat_t;

endpackage

/* design/dbf_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module dbf_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 65536,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/dbf_engine.sv */
// Frame store and the sweep sequencer that runs the border fill in place.
module dbf_engine #(
  parameter int unsigned MAX_WIDTH  = dbf_pkg::DBF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = dbf_pkg::DBF_MAX_HEIGHT,
  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT,
  localparam int unsigned AW    = $clog2(DEPTH),
  localparam int unsigned CW    = $clog2(MAX_WIDTH + 1),
  localparam int unsigned RW    = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dbf_pkg::dbf_host_req_t         host_i,
  input  logic [CW-1:0]                  width_i,
  input  logic [RW-1:0]                  height_i,
  input  logic [dbf_pkg::LIM_W-1:0]      limit_i,
  output logic                           busy_o,
  output logic [dbf_pkg::PIX_W-1:0]      rdata_o,
  output dbf_pkg::dbf_run_stat_t         stat_o
);

  localparam int unsigned PW = CW + RW;

  dbf_pkg::dbf_state_e state_q, state_d;
  dbf_pkg::dbf_sweep_e sweep_q, sweep_d;

  logic [AW-1:0]                 idx_q, idx_d;
  logic [AW-1:0]                 last_q, last_d;
  logic [CW-1:0]                 col_q, col_d;
  logic [dbf_pkg::PIX_W-1:0]     prev_pix_q, prev_pix_d;
  logic [dbf_pkg::CHG_W-1:0]     n_q, n_d, n_new;
  logic [dbf_pkg::LIM_W-1:0]     loops_q, loops_d, loops_n;
  logic [dbf_pkg::LIM_W-1:0]     rounds_q, rounds_d;
  logic                          hit_q, hit_d;
  logic [dbf_pkg::CHG_W-1:0]     chg_q, chg_d;
  logic                          done_q, done_d;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr, ram_raddr;
  logic [dbf_pkg::PIX_W-1:0]     ram_wdata, ram_rdata;

  logic [CW-1:0]                 wm1;
  logic [AW-1:0]                 w_ext;
  logic [AW-1:0]                 prev_addr;
  logic [PW-1:0]                 area;
  logic                          forced, chg, advance, sweep_end, round_end;

  dbf_ram #(
    .WIDTH (dbf_pkg::PIX_W),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign wm1   = width_i - 1'b1;
  assign w_ext = AW'(width_i);
  assign area  = PW'(width_i) * PW'(height_i);

  always_comb begin
    unique case (sweep_q)
      dbf_pkg::SWP_LR: prev_addr = idx_q - 1'b1;
      dbf_pkg::SWP_RL: prev_addr = idx_q + 1'b1;
      dbf_pkg::SWP_TD: prev_addr = idx_q - w_ext;
      dbf_pkg::SWP_BU: prev_addr = idx_q + w_ext;
      default:         prev_addr = idx_q;
    endcase
  end

  assign forced = ((sweep_q == dbf_pkg::SWP_LR) && (col_q == '0)) ||
                  ((sweep_q == dbf_pkg::SWP_RL) && (col_q == wm1));

  assign sweep_end = ((sweep_q == dbf_pkg::SWP_LR) || (sweep_q == dbf_pkg::SWP_TD)) ?
                     (idx_q == last_q) : (idx_q == '0);

  assign loops_n = loops_q + 1'b1;

  always_comb begin
    state_d    = state_q;
    sweep_d    = sweep_q;
    idx_d      = idx_q;
    last_d     = last_q;
    col_d      = col_q;
    prev_pix_d = prev_pix_q;
    n_d        = n_q;
    loops_d    = loops_q;
    rounds_d   = rounds_q;
    hit_d      = hit_q;
    chg_d      = chg_q;
    done_d     = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = idx_q;
    ram_wdata  = dbf_pkg::PIX_RED;
    ram_raddr  = idx_q;
    advance    = 1'b0;
    chg        = 1'b0;
    round_end  = 1'b0;

    unique case (state_q)
      dbf_pkg::ST_IDLE: begin
        ram_we    = host_i.wr;
        ram_waddr = AW'(host_i.index);
        ram_wdata = host_i.pix;
        ram_raddr = AW'(host_i.index);
        if (host_i.run) begin
          state_d = dbf_pkg::ST_SETUP;
        end
      end
      dbf_pkg::ST_SETUP: begin
        last_d  = AW'(area - 1'b1);
        loops_d = '0;
        n_d     = '0;
        sweep_d = dbf_pkg::SWP_LR;
        idx_d   = '0;
        col_d   = '0;
        state_d = dbf_pkg::ST_PREV;
      end
      dbf_pkg::ST_PREV: begin
        if (forced) begin
          ram_we  = 1'b1;
          advance = 1'b1;
        end else begin
          ram_raddr = prev_addr;
          state_d   = dbf_pkg::ST_AT;
        end
      end
      dbf_pkg::ST_AT: begin
        prev_pix_d = ram_rdata;
        state_d    = dbf_pkg::ST_UPD;
      end
      dbf_pkg::ST_UPD: begin
        chg     = (prev_pix_q == dbf_pkg::PIX_RED) && (ram_rdata == dbf_pkg::PIX_WHITE);
        ram_we  = chg;
        advance = 1'b1;
      end
      dbf_pkg::ST_CLR_RD: begin
        state_d = dbf_pkg::ST_CLR_WR;
      end
      dbf_pkg::ST_CLR_WR: begin
        ram_we    = (ram_rdata == dbf_pkg::PIX_RED);
        ram_wdata = dbf_pkg::PIX_BLACK;
        if (idx_q == last_q) begin
          done_d  = 1'b1;
          state_d = dbf_pkg::ST_IDLE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = dbf_pkg::ST_CLR_RD;
        end
      end
      default: state_d = dbf_pkg::ST_IDLE;
    endcase

    // Saturate the per-round change count.
    n_new = (chg && (n_q != dbf_pkg::CHANGE_MAX)) ? n_q + 1'b1 : n_q;

    if (advance) begin
      n_d     = n_new;
      state_d = dbf_pkg::ST_PREV;
      if (!sweep_end) begin
        unique case (sweep_q)
          dbf_pkg::SWP_LR: begin
            idx_d = idx_q + 1'b1;
            col_d = (col_q == wm1) ? '0 : col_q + 1'b1;
          end
          dbf_pkg::SWP_RL: begin
            idx_d = idx_q - 1'b1;
            col_d = (col_q == '0) ? wm1 : col_q - 1'b1;
          end
          dbf_pkg::SWP_TD: idx_d = idx_q + 1'b1;
          dbf_pkg::SWP_BU: idx_d = idx_q - 1'b1;
          default:         idx_d = idx_q;
        endcase
      end else begin
        unique case (sweep_q)
          dbf_pkg::SWP_LR: begin
            sweep_d = dbf_pkg::SWP_RL;
            idx_d   = last_q;
            col_d   = wm1;
          end
          dbf_pkg::SWP_RL: begin
            // A single row has no vertical sweeps.
            if (height_i != RW'(1)) begin
              sweep_d = dbf_pkg::SWP_TD;
              idx_d   = w_ext;
            end else begin
              round_end = 1'b1;
            end
          end
          dbf_pkg::SWP_TD: begin
            sweep_d = dbf_pkg::SWP_BU;
            idx_d   = last_q - w_ext;
          end
          dbf_pkg::SWP_BU: round_end = 1'b1;
          default:         round_end = 1'b1;
        endcase
      end

      if (round_end) begin
        if ((n_new == '0) || (loops_n == limit_i)) begin
          rounds_d = loops_n;
          hit_d    = (loops_n == limit_i);
          chg_d    = n_new;
          idx_d    = '0;
          state_d  = dbf_pkg::ST_CLR_RD;
        end else begin
          loops_d = loops_n;
          n_d     = '0;
          sweep_d = dbf_pkg::SWP_LR;
          idx_d   = '0;
          col_d   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dbf_pkg::ST_IDLE;
      sweep_q  <= dbf_pkg::SWP_LR;
      loops_q  <= '0;
      n_q      <= '0;
      rounds_q <= '0;
      hit_q    <= 1'b0;
      chg_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      sweep_q  <= sweep_d;
      loops_q  <= loops_d;
      n_q      <= n_d;
      rounds_q <= rounds_d;
      hit_q    <= hit_d;
      chg_q    <= chg_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    last_q     <= last_d;
    col_q      <= col_d;
    prev_pix_q <= prev_pix_d;
  end

  assign busy_o         = (state_q != dbf_pkg::ST_IDLE);
  assign rdata_o        = ram_rdata;
  assign stat_o.done    = done_q;
  assign stat_o.rounds  = rounds_q;
  assign stat_o.hit     = hit_q;
  assign stat_o.changes = chg_q;

endmodule

/* design/directional_border_fill.sv */
// Top level of the directional border fill: command port, configuration and results.
//
// Pixel writes, pixel reads and no-op commands are taken while busy is low; their
// result is on the outputs, marked by done_o, in the cycle right after the command.
// A run command raises busy and walks the frame store, whose single read port sets
// the pace: each pixel of a sweep takes three steps (read the predecessor, read the
// pixel, write back); the first pixel of each row in a horizontal sweep is written
// red directly. A round is four sweeps, two on a single-row frame; after the last
// round a cleanup pass reads each pixel and turns red into black. The single result
// of a run comes with done_o in the cycle busy falls. done_o lasts exactly one
// cycle and cannot be held off. The frame store is not cleared after reset; read only
// pixels that were written, and write every pixel of the frame in use before a run.
module directional_border_fill #(
  parameter int unsigned MAX_WIDTH  = dbf_pkg::DBF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = dbf_pkg::DBF_MAX_HEIGHT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  output logic                          done_o,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_addr_i,
  input  logic [dbf_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic [1:0]                    func_i,
  input  logic [dbf_pkg::IDX_W-1:0]     pixel_index_i,
  input  logic [7:0]                    in_red_i,
  input  logic [7:0]                    in_green_i,
  input  logic [7:0]                    in_blue_i,
  output logic [7:0]                    out_red_o,
  output logic [7:0]                    out_green_o,
  output logic [7:0]                    out_blue_o,
  output logic [dbf_pkg::LIM_W-1:0]     rounds_done_o,
  output logic                          hit_limit_o,
  output logic [dbf_pkg::CHG_W-1:0]     last_changes_o
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned CW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT + 1);

  logic [dbf_pkg::CFG_W-1:0] width_q, height_q;
  logic [dbf_pkg::LIM_W-1:0] limit_q;
  logic [CW-1:0]             eff_width;
  logic [RW-1:0]             eff_height;
  logic [dbf_pkg::LIM_W-1:0] eff_limit;

  logic                      accept, in_range;
  logic                      cmd_done_q, cmd_done_d;
  logic                      rd_q, rd_d;
  dbf_pkg::dbf_host_req_t    host_req;
  dbf_pkg::dbf_run_stat_t    stat;
  logic [dbf_pkg::PIX_W-1:0] rdata;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= dbf_pkg::WIDTH_RST;
      height_q <= dbf_pkg::HEIGHT_RST;
      limit_q  <= dbf_pkg::LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        dbf_pkg::CFG_FRAME_WIDTH:  width_q  <= cfg_wdata_i;
        dbf_pkg::CFG_FRAME_HEIGHT: height_q <= cfg_wdata_i;
        dbf_pkg::CFG_ROUND_LIMIT:  limit_q  <= cfg_wdata_i[dbf_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp geometry to between one and what the store supports; a zero round limit counts as one.
  always_comb begin
    if (width_q == '0) begin
      eff_width = CW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      eff_width = CW'(MAX_WIDTH);
    end else begin
      eff_width = CW'(width_q);
    end
    if (height_q == '0) begin
      eff_height = RW'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      eff_height = RW'(MAX_HEIGHT);
    end else begin
      eff_height = RW'(height_q);
    end
    eff_limit = (limit_q == '0) ? dbf_pkg::LIM_W'(1) : limit_q;
  end

  assign accept   = start && !busy;
  assign in_range = (32'(pixel_index_i) < DEPTH);

  always_comb begin
    host_req.wr    = 1'b0;
    host_req.run   = 1'b0;
    host_req.index = pixel_index_i;
    host_req.pix   = {in_red_i, in_green_i, in_blue_i};
    cmd_done_d     = 1'b0;
    rd_d           = 1'b0;
    if (accept) begin
      unique case (func_i)
        dbf_pkg::FUNC_WRITE: begin
          host_req.wr = in_range;
          cmd_done_d  = 1'b1;
        end
        dbf_pkg::FUNC_RUN: host_req.run = 1'b1;
        dbf_pkg::FUNC_READ: begin
          rd_d       = in_range;
          cmd_done_d = 1'b1;
        end
        default: cmd_done_d = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_done_q <= 1'b0;
      rd_q       <= 1'b0;
    end else begin
      cmd_done_q <= cmd_done_d;
      rd_q       <= rd_d;
    end
  end

  dbf_engine #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .host_i   (host_req),
    .width_i  (eff_width),
    .height_i (eff_height),
    .limit_i  (eff_limit),
    .busy_o   (busy),
    .rdata_o  (rdata),
    .stat_o   (stat)
  );

  assign done_o         = cmd_done_q || stat.done;
  assign out_red_o      = rd_q ? rdata[23:16] : 8'h00;
  assign out_green_o    = rd_q ? rdata[15:8]  : 8'h00;
  assign out_blue_o     = rd_q ? rdata[7:0]   : 8'h00;
  assign rounds_done_o  = stat.rounds;
  assign hit_limit_o    = stat.hit;
  assign last_changes_o = stat.changes;

  // A run result never appears while the run is still walking the frame.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.done |-> !busy)
    else $error("run result strobe while busy");

  // A read request answers in the very next cycle.
  a_read_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (func_i == dbf_pkg::FUNC_READ)) |=> done_o)
    else $error("read request without result");

  // A run request holds the block busy and produces no immediate run result.
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (func_i == dbf_pkg::FUNC_RUN)) |=> (busy && !stat.done))
    else $error("run request did not start");

  // The end of a run always delivers its result.
  a_run_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("run ended without result");

  // A limit hit implies at least one round ran.
  a_hit_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_limit_o |-> (rounds_done_o != '0))
    else $error("limit flag without rounds");

endmodule
